### src/mcsc_pkg.sv
// ----------------------------------------------------------------------------
// mcsc_pkg
// Shared types and widths for the stick cutting cost engine.
// ----------------------------------------------------------------------------
package mcsc_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned COST_W = 32;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [COST_W-1:0] cost_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRITE = 5'b01000,
    S_OUT   = 5'b10000
  } seq_state_t;

  // sequencer to datapath control
  typedef struct packed {
    logic issue;   // read C(i,k) and C(k,j) this cycle
    logic drain;   // last pair arrives, span is formed
    logic write;   // store C(i,j)
    logic a_zero;  // k = i+1, C(i,k) is an empty span
    logic b_zero;  // k = j-1, C(k,j) is an empty span
    logic i_zero;  // left point is the rod start
    logic j_rod;   // right point is the rod end
  } dp_ctrl_t;

endpackage

### src/mcsc_seq.sv
// ----------------------------------------------------------------------------
// mcsc_seq
// Sequencer walking the interval table by gap, start point and split point.
// ----------------------------------------------------------------------------
module mcsc_seq import mcsc_pkg::*; #(
  parameter int unsigned IW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [IW-1:0] last_idx,
  input  logic          out_free,
  output dp_ctrl_t      ctrl,
  output logic [IW-1:0] idx_i,
  output logic [IW-1:0] idx_j,
  output logic [IW-1:0] idx_k,
  output logic          idle,
  output logic          publish
);

  seq_state_t    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] gap_r, gap_nxt;
  logic [IW-1:0] last_r, last_nxt;

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    gap_nxt     = gap_r;
    last_nxt    = last_r;
    ctrl        = '0;
    ctrl.a_zero = (k_r == i_r + IW'(1));
    ctrl.b_zero = (k_r + IW'(1) == j_r);
    ctrl.i_zero = (i_r == '0);
    ctrl.j_rod  = (j_r == last_r);
    publish     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt  = last_idx;
          gap_nxt   = IW'(2);
          i_nxt     = '0;
          j_nxt     = IW'(2);
          k_nxt     = IW'(1);
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        ctrl.issue = 1'b1;
        if (ctrl.b_zero) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_DRAIN: begin
        ctrl.drain = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        ctrl.write = 1'b1;
        if (j_r == last_r) begin
          if (gap_r == last_r) begin
            state_nxt = S_OUT;
          end else begin
            // next diagonal
            gap_nxt   = gap_r + IW'(1);
            i_nxt     = '0;
            j_nxt     = gap_r + IW'(1);
            k_nxt     = IW'(1);
            state_nxt = S_ISSUE;
          end
        end else begin
          i_nxt     = i_r + IW'(1);
          j_nxt     = j_r + IW'(1);
          k_nxt     = i_r + IW'(2);
          state_nxt = S_ISSUE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          publish   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    gap_r  <= gap_nxt;
    last_r <= last_nxt;
  end

  assign idx_i = i_r;
  assign idx_j = j_r;
  assign idx_k = k_r;
  assign idle  = (state_r == S_IDLE);

endmodule

### src/mcsc_dp.sv
// ----------------------------------------------------------------------------
// mcsc_dp
// Position and cost stores with the shared add, compare and span unit.
// ----------------------------------------------------------------------------
module mcsc_dp import mcsc_pkg::*; #(
  parameter int unsigned NPTS = 34,
  parameter int unsigned IW   = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_ctrl_t      ctrl,
  input  logic [IW-1:0] idx_i,
  input  logic [IW-1:0] idx_j,
  input  logic [IW-1:0] idx_k,
  input  logic          pos_we,
  input  logic [IW-1:0] pos_waddr,
  input  pos_t          pos_wdata,
  input  pos_t          rod_length,
  output cost_t         result
);

  localparam int unsigned DEPTH = NPTS * NPTS;
  localparam int unsigned AW    = $clog2(DEPTH);

  pos_t  pos_mem  [NPTS];
  cost_t cost_mem [DEPTH];

  logic [AW-1:0] addr_a, addr_b, addr_w;
  cost_t         rd_a_r, rd_b_r;
  pos_t          pi_r, pj_r;
  logic          v1_r, first_r, az_r, bz_r, i0_r, jr_r;
  cost_t         best_r, sum;
  pos_t          span_r, pi_eff, pj_eff;
  cost_t         wdata;
  cost_t         res_r;

  assign addr_a = AW'(idx_i) * AW'(NPTS) + AW'(idx_k);
  assign addr_b = AW'(idx_k) * AW'(NPTS) + AW'(idx_j);
  assign addr_w = AW'(idx_i) * AW'(NPTS) + AW'(idx_j);

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (ctrl.issue) begin
      pi_r <= pos_mem[idx_i];
      pj_r <= pos_mem[idx_j];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      cost_mem[addr_w] <= wdata;
    end
    if (ctrl.issue) begin
      rd_a_r <= cost_mem[addr_a];
      rd_b_r <= cost_mem[addr_b];
    end
  end

  // spans of adjacent points hold no cut and cost nothing
  assign sum    = (az_r ? '0 : rd_a_r) + (bz_r ? '0 : rd_b_r);
  assign pi_eff = i0_r ? '0 : pi_r;
  assign pj_eff = jr_r ? rod_length : pj_r;
  assign wdata  = best_r + COST_W'(span_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= ctrl.a_zero;
    az_r    <= ctrl.a_zero;
    bz_r    <= ctrl.b_zero;
    i0_r    <= ctrl.i_zero;
    jr_r    <= ctrl.j_rod;
    if (v1_r && (first_r || sum < best_r)) begin
      best_r <= sum;
    end
    if (ctrl.drain) begin
      span_r <= (pj_eff >= pi_eff) ? pj_eff - pi_eff : pi_eff - pj_eff;
    end
    if (ctrl.write) begin
      res_r <= wdata;
    end
  end

  assign result = res_r;

endmodule

### src/min_cost_stick_cutting.sv
// ----------------------------------------------------------------------------
// min_cost_stick_cutting
// Minimum total cost of cutting a rod at a list of ascending positions.
// ----------------------------------------------------------------------------
// a cut that is not the last is taken back to back while the engine is idle
// the last cut of n stored starts the interval fill: for each table entry
// every split point is read and compared on the shared add-compare unit,
// then the span is formed and the entry written; once the output is free the
// result enters the output register; no input is taken meanwhile
// synchronous active-low reset clears control, cut counter and overflow flag and sets rod length to 1
module min_cost_stick_cutting import mcsc_pkg::*; #(
  parameter int unsigned MAX_CUTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_cut_position,
  input  logic        in_last_cut,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_total_cost,
  output logic        out_too_many_cuts
);

  localparam int unsigned NPTS = MAX_CUTS + 2;
  localparam int unsigned IW   = $clog2(NPTS);
  localparam int unsigned CW   = $clog2(MAX_CUTS + 1);

  pos_t          rod_r;
  logic [CW-1:0] count_r;
  logic          ovf_r, res_ovf_r;
  logic          out_valid_r, out_tmc_r;
  cost_t         out_cost_r;

  logic          accept, room, start, idle, publish, out_free;
  logic [IW-1:0] last_idx, pos_waddr;
  logic [IW-1:0] idx_i, idx_j, idx_k;
  dp_ctrl_t      ctrl;
  cost_t         result;

  assign in_ready  = idle;
  assign accept    = in_valid && in_ready;
  assign room      = (count_r < CW'(MAX_CUTS));
  assign start     = accept && in_last_cut;
  assign pos_waddr = IW'(count_r) + IW'(1);
  // index of the right endpoint once this transfer is stored
  assign last_idx  = room ? IW'(count_r) + IW'(2) : IW'(count_r) + IW'(1);
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rod_r   <= pos_t'(1);
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        rod_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_last_cut) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res_ovf_r <= ovf_r || !room;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_cost_r <= result;
      out_tmc_r  <= res_ovf_r;
    end
  end

  mcsc_seq #(.IW(IW)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_idx (last_idx),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idx_i    (idx_i),
    .idx_j    (idx_j),
    .idx_k    (idx_k),
    .idle     (idle),
    .publish  (publish)
  );

  mcsc_dp #(.NPTS(NPTS), .IW(IW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .idx_i      (idx_i),
    .idx_j      (idx_j),
    .idx_k      (idx_k),
    .pos_we     (accept && room),
    .pos_waddr  (pos_waddr),
    .pos_wdata  (in_cut_position),
    .rod_length (rod_r),
    .result     (result)
  );

  assign out_valid         = out_valid_r;
  assign out_total_cost    = out_cost_r;
  assign out_too_many_cuts = out_tmc_r;

endmodule

### src/mcsc_chk.sv
// ----------------------------------------------------------------------------
// mcsc_chk
// Port-level checks on load, compute and result transfer sequencing.
// ----------------------------------------------------------------------------
module mcsc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_cut,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_total_cost,
  input logic        out_too_many_cuts
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_cost)
      && $stable(out_too_many_cuts))
    else $error("result changed while stalled");

  // loading continues after a cut that is not the last
  a_load_more: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_cut |=> in_ready)
    else $error("input stalled during load");

  // the last cut starts the fill, no transfer is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_cut |=> !in_ready)
    else $error("input taken during table fill");

  // a result only appears from the busy phase
  a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a fill");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind min_cost_stick_cutting mcsc_chk u_chk (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the stick cutting cost engine against an interval cost predictor.
// Cut sets are streamed under several rod lengths, with random idle bursts on
// both channels outside the tail; every result is compared with the predicted minimum cost and
// capacity flag in order of arrival.
// ----------------------------------------------------------------------------
module tb;
  import mcsc_pkg::*;

  localparam int unsigned CUT_CAP    = 32;
  localparam int unsigned NPTS       = CUT_CAP + 2;
  localparam int unsigned ITEMS      = 1750;
  localparam int unsigned TAIL_START = 1500;

  class cut_cost_scoreboard;
    pos_t        points[NPTS];
    int unsigned stored;
    bit          dropped;
    pos_t        rod_len;
    cost_t       expected_costs[$];
    bit          expected_flags[$];
    int unsigned errors;

    function new();
      stored  = 0;
      dropped = 1'b0;
      rod_len = 16'd1;
      errors  = 0;
    endfunction

    function void set_rod(pos_t len);
      rod_len = len;
    endfunction

    function int unsigned pending();
      return expected_costs.size();
    endfunction

    // bottom-up fill over the framed points, shortest spans first
    function cost_t min_cut_cost();
      cost_t       tbl[NPTS][NPTS];
      cost_t       best;
      cost_t       sum;
      cost_t       lo;
      cost_t       hi;
      int unsigned npts;
      int unsigned j;
      npts = stored + 2;
      points[0] = '0;
      points[npts-1] = rod_len;
      for (int unsigned g = 1; g < npts; g++) begin
        for (int unsigned i = 0; i + g < npts; i++) begin
          j = i + g;
          if (g == 1) begin
            tbl[i][j] = '0;
          end else begin
            best = tbl[i][i+1] + tbl[i+1][j];
            for (int unsigned k = i + 2; k < j; k++) begin
              sum = tbl[i][k] + tbl[k][j];
              if (sum < best) best = sum;
            end
            lo = cost_t'(points[i]);
            hi = cost_t'(points[j]);
            tbl[i][j] = best + ((lo > hi) ? lo - hi : hi - lo);
          end
        end
      end
      return tbl[0][npts-1];
    endfunction

    function void note_cut(pos_t pos, bit last);
      if (stored < CUT_CAP) begin
        points[stored+1] = pos;
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        expected_costs = {expected_costs, min_cut_cost()};
        expected_flags = {expected_flags, dropped};
        stored  = 0;
        dropped = 1'b0;
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(cost_t cost, bit flag);
      cost_t exp_cost;
      bit    exp_flag;
      if (expected_costs.size() == 0) begin
        report($sformatf("result with nothing outstanding, cost %0d", cost));
        return;
      end
      exp_cost = expected_costs.pop_front();
      exp_flag = expected_flags.pop_front();
      if (cost !== exp_cost)
        report($sformatf("total_cost %0d, expected %0d", cost, exp_cost));
      if (flag !== exp_flag)
        report($sformatf("too_many_cuts %0b, expected %0b", flag, exp_flag));
    endtask
  endclass

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        cfg_we            = 1'b0;
  logic [15:0] cfg_wdata         = '0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [15:0] in_cut_position   = '0;
  logic        in_last_cut       = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [31:0] out_total_cost;
  logic        out_too_many_cuts;

  cut_cost_scoreboard sb;
  bit                 idling = 1'b1;
  int unsigned        sent   = 0;
  int unsigned        ready_hold = 0;

  min_cost_stick_cutting #(
    .MAX_CUTS(CUT_CAP)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cut_position  (in_cut_position),
    .in_last_cut      (in_last_cut),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_total_cost   (out_total_cost),
    .out_too_many_cuts(out_too_many_cuts)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: check each transfer, then decide on a stall burst
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_total_cost, out_too_many_cuts);
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= (ready_hold == 0);
    end else if (rst_n && idling && $urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid is left high after a transfer so that the next cut can follow
  // back to back; the caller moves on without letting time pass
  task automatic send_cut(input pos_t pos, input bit last);
    int unsigned gap;
    if (idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cut_position <= pos;
    in_last_cut     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_cut(pos, last);
    sent++;
  endtask

  task automatic send_set(input int unsigned n, input bit scrambled);
    int          q[$];
    int unsigned hi;
    hi = (sb.rod_len > 1) ? sb.rod_len - 1 : 1;
    for (int unsigned c = 0; c < n; c++)
      q = {q, int'(scrambled ? $urandom_range(0, 65535) : $urandom_range(1, hi))};
    if (!scrambled) q.sort();
    foreach (q[c])
      send_cut(pos_t'(q[c]), c == q.size() - 1);
  endtask

  // rod length changes only with the engine drained and quiet
  task automatic settle_then_write(input pos_t len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_rod(len);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned phase;
    int unsigned r;
    int unsigned n;
    pos_t        rod;
    sb = new();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rod length straight out of reset
    send_cut(16'd1, 1'b1);

    settle_then_write(16'hFFFF);
    send_cut(16'd1, 1'b0);
    send_cut(16'hFFFE, 1'b1);
    send_cut(16'h8000, 1'b1);
    // unordered, and points on the rod ends
    send_cut(16'hFFFF, 1'b0);
    send_cut(16'd0, 1'b0);
    send_cut(16'h9C40, 1'b1);

    // zero rod length, right endpoint sits at the origin
    settle_then_write(16'd0);
    send_cut(16'd5, 1'b0);
    send_cut(16'd3, 1'b1);

    settle_then_write(16'd1000);
    send_cut(16'd10, 1'b0);
    send_cut(16'd20, 1'b0);
    send_cut(16'd30, 1'b1);

    phase_end = sent;
    phase     = 0;
    while (sent < ITEMS) begin
      if (sent >= phase_end) begin
        case ($urandom_range(0, 5))
          0:       rod = 16'hFFFF;
          1:       rod = 16'd0;
          2:       rod = pos_t'($urandom_range(2, 64));
          default: rod = pos_t'($urandom_range(1, 65535));
        endcase
        if (phase == 0) rod = 16'd1;
        settle_then_write(rod);
        phase_end = sent + $urandom_range(150, 300);
        phase++;
      end
      idling = (sent < TAIL_START);
      r = $urandom_range(0, 99);
      if (r < 75)      n = $urandom_range(1, 8);
      else if (r < 90) n = $urandom_range(9, 31);
      else             n = $urandom_range(32, 40);
      send_set(n, $urandom_range(0, 9) == 0);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### min_cost_stick_cutting.f
src/mcsc_pkg.sv
src/mcsc_seq.sv
src/mcsc_dp.sv
src/min_cost_stick_cutting.sv
src/mcsc_chk.sv
tb/tb.sv
